// ===== src/tts_pkg.sv =====
// tts_pkg: shared types, codes and constants of the tilt target sequencer
// depends on nothing
`timescale 1ns / 1ps
package tts_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_ACCEL      = 3'd1,
    OP_SET_DIRECT = 3'd2,
    OP_EXIT       = 3'd3,
    OP_START      = 3'd4,
    OP_STOP       = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    REG_GAIN_FWD   = 3'd0,
    REG_GAIN_BRAKE = 3'd1,
    REG_OFFSET     = 3'd2,
    REG_TRIM       = 3'd3,
    REG_PITCH      = 3'd4,
    REG_MAX_STEP   = 3'd5,
    REG_STEP_ANG   = 3'd6,
    REG_STEP_DUR   = 3'd7
  } reg_idx_t;

  localparam int AFF_W   = 21;  // gain*accel rounded plus offset
  localparam int CORD_W  = 38;  // cordic x and y
  localparam int ZACC_W  = 32;  // angle accumulator
  localparam int PHI_W   = 17;
  localparam int TGT_W   = 18;
  localparam int STEP_FW = 14;
  localparam int ANGLE_MAX = 18000;

  // atan(2^-i) in 0.01 deg / 65536
  function automatic logic [28:0] atan_at(input logic [4:0] i);
    logic [28:0] v;
    unique case (i)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183347;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/tilt_target_sequencer_slew_core.sv =====
// tilt_target_sequencer_slew_core: top level of the tilt target sequencer
// depends on tts_pkg, tts_mult, tts_cordic
//
// usage: command words enter on in_* (valid/ready); each tick word yields one
// result word on out_* unless it ends a running sequence. other opcodes only
// change state. the user must write registers on cfg_* only while the block is
// idle; the block itself does not enforce it, and cfg_ready is always high.
// a tick in sequence or direct mode passes from S_IDLE through S_SLEW into the
// output register; in feedforward mode it first runs the bit-serial multiply
// (S_MUL) and the cordic iterations (S_CORD) before S_SLEW. one word is worked
// on at a time.
// the result sits in an output register: a new word is taken while it waits,
// but a tick that finishes while the receiver stalls holds until out_ready.
// reset (synchronous, rst_n low) clears control state, loads register defaults.
`timescale 1ns / 1ps
module tilt_target_sequencer_slew_core #(
  parameter int GRAVITY_MM        = 9807,
  parameter int STEP_COUNT        = 4,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic signed [15:0] in_operand_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_target_angle,
  output logic        out_direct_active,
  output logic        out_sequence_active,
  output logic [1:0]  out_sequence_step,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [55:0] cfg_data
);
  import tts_pkg::*;

  localparam int SIW = (STEP_COUNT > 4) ? 3 : 2;
  localparam logic [SIW-1:0] LAST_STEP = SIW'(STEP_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CORD = 4'b0100,
    S_SLEW = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] gf_r, gb_r, off_r, trim_r, pitch_r;
  logic [14:0]        lim_r;
  logic [55:0]        sang_r, sdur_r;

  logic signed [15:0] accel_r, accel_nxt, prev_r, prev_nxt, dtgt_r, dtgt_nxt;
  logic               dir_r, dir_nxt, run_r, run_nxt;
  logic [SIW-1:0]     step_r, step_nxt;
  logic [13:0]        elap_r, elap_nxt;
  logic signed [TGT_W-1:0] tgt_r, tgt_nxt;

  logic               ov_r, ov_nxt;
  logic signed [15:0] oang_r, oang_nxt;
  logic               odir_r, odir_nxt, orun_r, orun_nxt;
  logic [1:0]         ostep_r, ostep_nxt;

  logic               mul_start, mul_done, cord_start, cord_done;
  logic signed [31:0] prod;
  logic signed [15:0] gain_sel;
  logic signed [AFF_W-1:0] a_ff;
  logic signed [PHI_W-1:0] phi;
  logic signed [31:0] prod_rnd;

  logic [14:0]        e;
  logic [13:0]        dur;
  logic [13:0]        ang14;
  logic signed [TGT_W:0] lo, hi, v;
  logic               accept, take_out;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign take_out  = !ov_r || out_ready;

  assign gain_sel = accel_r[15] ? gb_r : gf_r;
  assign prod_rnd = prod + 32'sd2048;
  assign a_ff     = AFF_W'(prod_rnd >>> 12) + AFF_W'(off_r);

  tts_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (gain_sel),
    .b       (accel_r),
    .done    (mul_done),
    .product (prod)
  );

  tts_cordic #(
    .GRAVITY_MM (GRAVITY_MM),
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .a_ff  (a_ff),
    .done  (cord_done),
    .phi   (phi)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gf_r    <= 16'sd4096;
      gb_r    <= 16'sd4096;
      off_r   <= '0;
      trim_r  <= '0;
      pitch_r <= '0;
      lim_r   <= 15'd40;
      sang_r  <= 56'd40532950840;
      sdur_r  <= 56'd2638881597030800;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_FWD:   gf_r    <= cfg_data[15:0];
        REG_GAIN_BRAKE: gb_r    <= cfg_data[15:0];
        REG_OFFSET:     off_r   <= cfg_data[15:0];
        REG_TRIM:       trim_r  <= cfg_data[15:0];
        REG_PITCH:      pitch_r <= cfg_data[15:0];
        REG_MAX_STEP:   lim_r   <= cfg_data[14:0];
        REG_STEP_ANG:   sang_r  <= cfg_data;
        REG_STEP_DUR:   sdur_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    accel_nxt  = accel_r;
    prev_nxt   = prev_r;
    dtgt_nxt   = dtgt_r;
    dir_nxt    = dir_r;
    run_nxt    = run_r;
    step_nxt   = step_r;
    elap_nxt   = elap_r;
    tgt_nxt    = tgt_r;
    ov_nxt     = ov_r && !out_ready;
    oang_nxt   = oang_r;
    odir_nxt   = odir_r;
    orun_nxt   = orun_r;
    ostep_nxt  = ostep_r;
    mul_start  = 1'b0;
    cord_start = 1'b0;
    e          = {1'b0, elap_r} + 15'd1;
    dur        = (step_r > SIW'(3)) ? 14'd0 : sdur_r[14*step_r[1:0] +: 14];
    ang14      = 14'd0;
    lo         = (TGT_W+1)'(prev_r) - (TGT_W+1)'($signed({1'b0, lim_r}));
    hi         = (TGT_W+1)'(prev_r) + (TGT_W+1)'($signed({1'b0, lim_r}));
    v          = (TGT_W+1)'(tgt_r);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v > (TGT_W+1)'(ANGLE_MAX)) v = (TGT_W+1)'(ANGLE_MAX);
    if (v < -(TGT_W+1)'(ANGLE_MAX)) v = -(TGT_W+1)'(ANGLE_MAX);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority case (in_opcode)
            OP_ACCEL: accel_nxt = in_operand_value;
            OP_SET_DIRECT: begin
              dir_nxt  = 1'b1;
              dtgt_nxt = in_operand_value;
            end
            OP_EXIT: begin
              dir_nxt = 1'b0;
              run_nxt = 1'b0;
            end
            OP_START: begin
              run_nxt  = 1'b1;
              step_nxt = '0;
              elap_nxt = '0;
              dir_nxt  = 1'b1;
            end
            OP_STOP: run_nxt = 1'b0;
            OP_TICK: begin
              if (run_r) begin
                if (e >= {1'b0, dur}) begin
                  e = '0;
                  if (step_r < LAST_STEP) begin
                    step_nxt = step_r + SIW'(1);
                  end else begin
                    run_nxt  = 1'b0;
                    step_nxt = '0;
                    dir_nxt  = 1'b0;
                  end
                end
                elap_nxt = e[13:0];
                ang14 = (step_nxt > SIW'(3)) ? 14'd0 : sang_r[14*step_nxt[1:0] +: 14];
                tgt_nxt = TGT_W'(signed'(ang14));
                if (run_nxt) state_nxt = S_SLEW;
              end else if (dir_r) begin
                tgt_nxt   = TGT_W'(dtgt_r);
                state_nxt = S_SLEW;
              end else begin
                mul_start = 1'b1;
                state_nxt = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          cord_start = 1'b1;
          state_nxt  = S_CORD;
        end
      end
      S_CORD: begin
        if (cord_done) begin
          tgt_nxt   = TGT_W'(phi) - TGT_W'(pitch_r) + TGT_W'(trim_r);
          state_nxt = S_SLEW;
        end
      end
      S_SLEW: begin
        if (take_out) begin
          prev_nxt  = 16'(v);
          ov_nxt    = 1'b1;
          oang_nxt  = 16'(v);
          odir_nxt  = dir_r;
          orun_nxt  = run_r;
          ostep_nxt = 2'(step_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      accel_r <= '0;
      prev_r  <= '0;
      dtgt_r  <= '0;
      dir_r   <= 1'b0;
      run_r   <= 1'b0;
      step_r  <= '0;
      elap_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      accel_r <= accel_nxt;
      prev_r  <= prev_nxt;
      dtgt_r  <= dtgt_nxt;
      dir_r   <= dir_nxt;
      run_r   <= run_nxt;
      step_r  <= step_nxt;
      elap_r  <= elap_nxt;
      ov_r    <= ov_nxt;
    end
    tgt_r   <= tgt_nxt;
    oang_r  <= oang_nxt;
    odir_r  <= odir_nxt;
    orun_r  <= orun_nxt;
    ostep_r <= ostep_nxt;
  end

  assign out_valid           = ov_r;
  assign out_target_angle    = oang_r;
  assign out_direct_active   = odir_r;
  assign out_sequence_active = orun_r;
  assign out_sequence_step   = ostep_r;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_angle <= 16'sd18000 && out_target_angle >= -16'sd18000))
    else $error("target out of range");
  a_seq_implies_direct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sequence_active |-> out_direct_active)
    else $error("sequence word without direct mode");
  a_mul_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiply finished outside its state");
  a_cord_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> state_r == S_CORD)
    else $error("cordic finished outside its state");
`endif

endmodule

// ===== src/tts_mult.sv =====
// tts_mult: bit-serial signed 16x16 multiplier, one multiplier bit per cycle
// depends on nothing
`timescale 1ns / 1ps
module tts_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               done,
  output logic signed [31:0] product
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] ash_r, ash_nxt;
  logic [15:0] bsh_r, bsh_nxt;
  logic [31:0] addend;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    bsh_nxt  = bsh_r;
    addend   = bsh_r[0] ? ash_r : 32'd0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      acc_nxt  = 32'd0;
      ash_nxt  = {{16{a[15]}}, a};
      bsh_nxt  = b;
    end else if (busy_r) begin
      // sign bit of b carries negative weight
      acc_nxt = (cnt_r == 4'd15) ? acc_r - addend : acc_r + addend;
      ash_nxt = {ash_r[30:0], 1'b0};
      bsh_nxt = {1'b0, bsh_r[15:1]};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    bsh_r <= bsh_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== src/tts_cordic.sv =====
// tts_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on tts_pkg
`timescale 1ns / 1ps
module tts_cordic #(
  parameter int GRAVITY_MM = 9807,
  parameter int ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [tts_pkg::AFF_W-1:0] a_ff,
  output logic                          done,
  output logic signed [tts_pkg::PHI_W-1:0] phi
);
  import tts_pkg::*;

  localparam int NIT = (ITERATIONS < 24) ? ITERATIONS : 24;
  localparam logic [4:0] LAST = 5'(NIT - 1);
  localparam logic signed [CORD_W-1:0] X0 = CORD_W'(GRAVITY_MM * 4096);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ZACC_W-1:0] z_r, z_nxt, ang;
  logic signed [PHI_W-1:0]  phi_r, phi_nxt;
  logic signed [ZACC_W:0]   rnd;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    phi_nxt  = phi_r;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    ang      = ZACC_W'({1'b0, atan_at(cnt_r)});
    rnd      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      x_nxt    = X0;
      y_nxt    = {{(CORD_W-AFF_W-12){a_ff[AFF_W-1]}}, a_ff, 12'd0};
      z_nxt    = '0;
    end else if (busy_r) begin
      if (!y_r[CORD_W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ang;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // negate and round half up to 0.01 deg
        rnd      = (ZACC_W+1)'(32768) - {z_nxt[ZACC_W-1], z_nxt};
        phi_nxt  = PHI_W'(rnd >>> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    phi_r <= phi_nxt;
  end

  assign done = done_r;
  assign phi  = phi_r;

endmodule
